FILE: design/wsd_pkg.sv
package wsd_pkg;

    localparam int LEN_BITS = 32;
    localparam int ACC_BITS = 64;
    localparam int CFG_BITS = 32;

    localparam logic [CFG_BITS-1:0] MAX_LEN_RESET = 32'd65536;

    localparam logic [7:0] FHB_TEXT_FINAL = 8'h81;
    localparam logic [6:0] LEN7_EXT16     = 7'd126;
    localparam logic [6:0] LEN7_EXT64     = 7'd127;
    localparam logic [3:0] EXT16_BYTES    = 4'd2;
    localparam logic [3:0] EXT64_BYTES    = 4'd8;

    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_UNMASKED = 3'd1,
        ERR_LONG     = 3'd2,
        ERR_CLOSE    = 3'd3,
        ERR_BINARY   = 3'd4,
        ERR_NOT_NUL  = 3'd5
    } err_t;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_LEN1    = 3'd1,
        PH_LENEXT  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_SKIP    = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       frame_final;
        err_t       error_code;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: design/wsd_front.sv
module wsd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_in_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsd_pkg::CFG_BITS-1:0]  cfg_max_frame_len,
    input  wsd_pkg::q_status_t            q_status,
    output logic                          push_valid,
    output wsd_pkg::res_t                 push_item
);

    wsd_pkg::phase_t                  phase_reg, phase_next;
    logic [7:0]                       fhb_reg, fhb_next;
    logic [wsd_pkg::ACC_BITS-1:0]     acc_reg, acc_next;
    logic [3:0]                       ext_reg, ext_next;
    logic [31:0]                      key_reg, key_next;
    logic [2:0]                       seen_reg, seen_next;
    logic [wsd_pkg::LEN_BITS-1:0]     pos_reg, pos_next;
    logic [wsd_pkg::LEN_BITS-1:0]     len_reg, len_next;
    logic                             halted_reg, halted_next;
    logic [wsd_pkg::CFG_BITS-1:0]     max_len_reg;

    logic                             accept;
    logic                             res_valid;
    wsd_pkg::res_t                    res;
    logic [6:0]                       len7;
    logic [wsd_pkg::ACC_BITS-1:0]     acc_shift;
    logic [3:0]                       ext_dec;
    logic [31:0]                      key_shift;
    logic [2:0]                       seen_inc;
    logic [wsd_pkg::LEN_BITS-1:0]     pos_inc;
    logic [1:0]                       key_sel;
    logic [7:0]                       data;
    logic                             last;
    logic [3:0]                       op;

    function automatic logic len_bad(input logic [wsd_pkg::ACC_BITS-1:0] len,
                                     input logic [wsd_pkg::CFG_BITS-1:0] max_len);
        return (len[wsd_pkg::ACC_BITS-1:wsd_pkg::CFG_BITS] != '0)
            || (len[wsd_pkg::CFG_BITS-1:0] > max_len)
            || (len[wsd_pkg::ACC_BITS-1:wsd_pkg::LEN_BITS] != '0);
    endfunction

    assign s_ready   = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    assign len7      = s_in_byte[6:0];
    assign acc_shift = {acc_reg[wsd_pkg::ACC_BITS-9:0], s_in_byte};
    assign ext_dec   = ext_reg - 4'd1;
    assign key_shift = {key_reg[23:0], s_in_byte};
    assign seen_inc  = seen_reg + 3'd1;
    assign pos_inc   = pos_reg + {{(wsd_pkg::LEN_BITS-1){1'b0}}, 1'b1};
    assign key_sel   = 2'd3 - pos_reg[1:0];
    assign data      = s_in_byte ^ key_reg[{key_sel, 3'b000} +: 8];
    assign last      = (pos_inc == len_reg);
    assign op        = fhb_reg[3:0];

    always_comb begin
        phase_next  = phase_reg;
        fhb_next    = fhb_reg;
        acc_next    = acc_reg;
        ext_next    = ext_reg;
        key_next    = key_reg;
        seen_next   = seen_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        halted_next = halted_reg;
        res_valid   = 1'b0;
        res         = '{out_byte: 8'd0, frame_end: 1'b0, frame_final: 1'b0,
                        error_code: wsd_pkg::ERR_NONE};
        case (phase_reg)
            wsd_pkg::PH_LEN1: begin
                if (!s_in_byte[7]) begin
                    res_valid      = 1'b1;
                    res.error_code = wsd_pkg::ERR_UNMASKED;
                end else if (len7 == wsd_pkg::LEN7_EXT16) begin
                    ext_next   = wsd_pkg::EXT16_BYTES;
                    phase_next = wsd_pkg::PH_LENEXT;
                end else if (len7 == wsd_pkg::LEN7_EXT64) begin
                    ext_next   = wsd_pkg::EXT64_BYTES;
                    phase_next = wsd_pkg::PH_LENEXT;
                end else if (len_bad({{(wsd_pkg::ACC_BITS-7){1'b0}}, len7}, max_len_reg)) begin
                    res_valid      = 1'b1;
                    res.error_code = wsd_pkg::ERR_LONG;
                end else begin
                    len_next   = {{(wsd_pkg::LEN_BITS-7){1'b0}}, len7};
                    phase_next = wsd_pkg::PH_MASK;
                end
            end
            wsd_pkg::PH_LENEXT: begin
                acc_next = acc_shift;
                ext_next = ext_dec;
                if (ext_dec == 4'd0) begin
                    if (len_bad(acc_shift, max_len_reg)) begin
                        res_valid      = 1'b1;
                        res.error_code = wsd_pkg::ERR_LONG;
                    end else begin
                        len_next   = acc_shift[wsd_pkg::LEN_BITS-1:0];
                        phase_next = wsd_pkg::PH_MASK;
                    end
                end
            end
            wsd_pkg::PH_MASK: begin
                key_next  = key_shift;
                seen_next = seen_inc;
                if (seen_inc[2]) begin
                    if (op == wsd_pkg::OP_CLOSE) begin
                        res_valid      = 1'b1;
                        res.error_code = wsd_pkg::ERR_CLOSE;
                    end else if (op == wsd_pkg::OP_BINARY) begin
                        res_valid      = 1'b1;
                        res.error_code = wsd_pkg::ERR_BINARY;
                    end else if (len_reg == '0) begin
                        phase_next = wsd_pkg::PH_START;
                    end else if (op > wsd_pkg::OP_BINARY) begin
                        phase_next = wsd_pkg::PH_SKIP;
                    end else begin
                        phase_next = wsd_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsd_pkg::PH_SKIP: begin
                pos_next = pos_inc;
                if (last) begin
                    phase_next = wsd_pkg::PH_START;
                end
            end
            wsd_pkg::PH_PAYLOAD: begin
                pos_next  = pos_inc;
                res_valid = 1'b1;
                if (last && fhb_reg == wsd_pkg::FHB_TEXT_FINAL && data != 8'd0) begin
                    res.error_code = wsd_pkg::ERR_NOT_NUL;
                end else begin
                    res.out_byte    = data;
                    res.frame_end   = last;
                    res.frame_final = fhb_reg[7];
                    if (last) begin
                        phase_next = wsd_pkg::PH_START;
                    end
                end
            end
            default: begin
                fhb_next   = s_in_byte;
                acc_next   = '0;
                ext_next   = 4'd0;
                key_next   = 32'd0;
                seen_next  = 3'd0;
                pos_next   = '0;
                len_next   = '0;
                phase_next = wsd_pkg::PH_LEN1;
            end
        endcase
        if (res_valid && res.error_code != wsd_pkg::ERR_NONE) begin
            halted_next = 1'b1;
        end
    end

    assign push_valid = accept && !halted_reg && res_valid;
    assign push_item  = res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= wsd_pkg::PH_START;
            fhb_reg     <= 8'd0;
            acc_reg     <= '0;
            ext_reg     <= 4'd0;
            key_reg     <= 32'd0;
            seen_reg    <= 3'd0;
            pos_reg     <= '0;
            len_reg     <= '0;
            halted_reg  <= 1'b0;
            max_len_reg <= wsd_pkg::MAX_LEN_RESET;
        end else begin
            if (cfg_valid) begin
                max_len_reg <= cfg_max_frame_len;
            end
            if (accept && !halted_reg) begin
                phase_reg  <= phase_next;
                fhb_reg    <= fhb_next;
                acc_reg    <= acc_next;
                ext_reg    <= ext_next;
                key_reg    <= key_next;
                seen_reg   <= seen_next;
                pos_reg    <= pos_next;
                len_reg    <= len_next;
                halted_reg <= halted_next;
            end
        end
    end

endmodule

FILE: design/wsd_queue.sv
module wsd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  wsd_pkg::res_t       push_item,
    input  logic                pop,
    output wsd_pkg::res_t       head_item,
    output wsd_pkg::q_status_t  q_status
);

    wsd_pkg::res_t  entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push;
    logic           do_pop;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);
    assign do_push        = push_valid && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_item      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/wsd_back.sv
module wsd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  wsd_pkg::q_status_t  q_status,
    input  wsd_pkg::res_t       head_item,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_frame_end,
    output logic                m_frame_final,
    output logic [2:0]          m_error_code
);

    logic           valid_reg;
    wsd_pkg::res_t  item_reg;

    assign pop           = !q_status.empty && (!valid_reg || m_ready);
    assign m_valid       = valid_reg;
    assign m_out_byte    = item_reg.out_byte;
    assign m_frame_end   = item_reg.frame_end;
    assign m_frame_final = item_reg.frame_final;
    assign m_error_code  = item_reg.error_code;

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= head_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

FILE: design/websocket_client_frame_deframer.sv
// A result is queued when its byte is accepted and then loaded into the output register.
// Throughput: one byte per cycle while the queue is not full (s_ready is low when it is full).
// A two-entry queue and an output register let the parser run while m_ready is low.
// Reset: aresetn is synchronous, active low; it clears the parser, the queue and the halt flag.
// Reset also restores max_frame_len to 65536.
module websocket_client_frame_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_in_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [wsd_pkg::CFG_BITS-1:0]  cfg_max_frame_len,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_frame_end,
    output logic                          m_frame_final,
    output logic [2:0]                    m_error_code
);

    wsd_pkg::q_status_t  q_status;
    logic                push_valid;
    wsd_pkg::res_t       push_item;
    logic                pop;
    wsd_pkg::res_t       head_item;

    wsd_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_in_byte         (s_in_byte),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_max_frame_len (cfg_max_frame_len),
        .q_status          (q_status),
        .push_valid        (push_valid),
        .push_item         (push_item)
    );

    wsd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop        (pop),
        .head_item  (head_item),
        .q_status   (q_status)
    );

    wsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .head_item     (head_item),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_end   (m_frame_end),
        .m_frame_final (m_frame_final),
        .m_error_code  (m_error_code)
    );

endmodule
